// File: rtl/core/rwci_pkg.sv
package rwci_pkg;

    localparam int MAX_TAPS_DEFAULT = 64;
    localparam int IDX_W            = 6;
    localparam int IDX_SLOTS        = 1 << IDX_W;
    localparam int COEF_W           = 16;
    localparam int PIX_W            = 8;
    localparam int POS_W            = 12;
    localparam int PROD_W           = COEF_W + PIX_W;
    localparam int ACC_W            = 32;
    localparam int SUM_W            = 24;
    localparam int INT_W            = 8;
    localparam int LUMA_P_W         = SUM_W + COEF_W;
    localparam int LUMA_Y_W         = LUMA_P_W + 2;
    localparam int TOT_W            = SUM_W + 2;
    localparam int AVG_T_W          = TOT_W - COEF_W;
    localparam int AVG_P_W          = 2 * AVG_T_W;

    localparam logic [COEF_W-1:0]  LUMA_WR = 16'd19595;
    localparam logic [COEF_W-1:0]  LUMA_WG = 16'd38470;
    localparam logic [COEF_W-1:0]  LUMA_WB = 16'd7471;

    // floor(t / 3) = (t * 683) >> 11 for t < 768
    localparam logic [AVG_T_W-1:0] AVG_RECIP = 10'd683;
    localparam int                 AVG_SHIFT = 11;

    localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};
    localparam logic [ACC_W-1:0]   ACC_MAX = {ACC_W{1'b1}};

    localparam logic               MODE_LOAD  = 1'b0;
    localparam logic               MODE_PIXEL = 1'b1;
    localparam logic               INT_AVG    = 1'b0;
    localparam logic               INT_LUMA   = 1'b1;

    localparam int OUT_FIFO_DEPTH = 8;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [INT_W-1:0] intensity;
        logic             overflow;
    } t_result;

endpackage

// File: rtl/core/rwci_ifs.sv
interface rwci_pix_if
    import rwci_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  coeff_index;
    logic [COEF_W-1:0] coeff_value;
    logic [PIX_W-1:0]  pixel_r;
    logic [PIX_W-1:0]  pixel_g;
    logic [PIX_W-1:0]  pixel_b;
    logic              last_pixel;
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;

    modport source (output valid, mode, coeff_index, coeff_value, pixel_r, pixel_g, pixel_b,
                    last_pixel, cell_row, cell_col, input ready);
    modport sink   (input valid, mode, coeff_index, coeff_value, pixel_r, pixel_g, pixel_b,
                    last_pixel, cell_row, cell_col, output ready);
endinterface

interface rwci_res_if
    import rwci_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [INT_W-1:0] intensity;
    logic             overflow;

    modport source (output valid, out_row, out_col, sum_r, sum_g, sum_b, intensity, overflow,
                    input ready);
    modport sink   (input valid, out_row, out_col, sum_r, sum_g, sum_b, intensity, overflow,
                    output ready);
endinterface

interface rwci_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/rgb_window_convolve_intensity_core.sv
// RGB window convolution with intensity.
//
// i_in (sink): one word per handshake. mode 0 loads coeff_value into slot
// coeff_index; mode 1 is a window pixel in raster order, last_pixel closing
// the window. Pixels use the coefficient slots in order from slot 0.
// o_out (source): one word per closed window: position, Q8.16 channel sums
// saturated with an overflow flag, and the intensity picked by i_cfg.
// i_cfg (sink): one-bit intensity mode, 0 average, 1 luma; always ready.
//
// Throughput is one input word per cycle while i_in.ready is high. A result
// passes coefficient memory read, multiply, accumulate, luma/average
// multiply, and final sum and select before entering the output FIFO.
// Results queue in an 8-word output FIFO; a credit count covers words in
// flight, so input is held off only when 8 results are outstanding while
// the receiver stalls. Non-last pixels keep flowing otherwise.
// Reset clears the tap counter, accumulators, mode, FIFO pointers and all
// valid bits; coefficient memory contents are undefined until loaded.
module rgb_window_convolve_intensity_core
    import rwci_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwci_pix_if.sink   i_in,
    rwci_cfg_if.sink   i_cfg,
    rwci_res_if.source o_out
);

    localparam int STORE_DEPTH = (MAX_TAPS < IDX_SLOTS) ? MAX_TAPS : IDX_SLOTS;
    localparam int TAP_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FPTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W       = $clog2(OUT_FIFO_DEPTH + 1);

    logic [COEF_W-1:0] r_mem [STORE_DEPTH];

    logic              r_intensity_mode;
    logic [TAP_W-1:0]  r_tap, n_tap;

    // stage 1: coefficient read
    logic              r_v1, r_last1;
    logic [COEF_W-1:0] r_coef1;
    logic [PIX_W-1:0]  r_pr1, r_pg1, r_pb1;
    logic [POS_W-1:0]  r_row1, r_col1;

    // stage 2: products
    logic              r_v2, r_last2;
    logic [PROD_W-1:0] r_mr2, r_mg2, r_mb2;
    logic [POS_W-1:0]  r_row2, r_col2;

    logic [ACC_W-1:0]  r_acc_r, r_acc_g, r_acc_b;
    logic [ACC_W-1:0]  n_acc_r, n_acc_g, n_acc_b;

    // stage 3: clipped sums
    logic              r_v3, r_ovf3;
    logic [SUM_W-1:0]  r_sr3, r_sg3, r_sb3;
    logic [POS_W-1:0]  r_row3, r_col3;

    // stage 4: luma products and average numerator
    logic                r_v4, r_ovf4;
    logic [SUM_W-1:0]    r_sr4, r_sg4, r_sb4;
    logic [POS_W-1:0]    r_row4, r_col4;
    logic [LUMA_P_W-1:0] r_lr4, r_lg4, r_lb4;
    logic [AVG_T_W-1:0]  r_t4;

    logic [TOT_W-1:0]    tot3;
    logic [LUMA_Y_W-1:0] luma_y;
    logic [AVG_P_W-1:0]  avg_p;
    logic [INT_W-1:0]    inten;

    t_result           r_fifo [OUT_FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]  r_fcnt, r_cnt;

    logic acc_in, acc_out, win_end;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [PROD_W-1:0] p);
        logic [ACC_W:0] t;
        t = {1'b0, a} + {{(ACC_W + 1 - PROD_W){1'b0}}, p};
        return t[ACC_W] ? ACC_MAX : t[ACC_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] clip(input logic [ACC_W-1:0] a);
        return (a > {{(ACC_W - SUM_W){1'b0}}, SUM_MAX}) ? SUM_MAX : a[SUM_W-1:0];
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_cnt < CNT_W'(OUT_FIFO_DEPTH));
    assign acc_in      = i_in.valid && i_in.ready;
    assign acc_out     = o_out.valid && o_out.ready;
    assign win_end     = acc_in && (i_in.mode == MODE_PIXEL) && i_in.last_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity_mode <= INT_AVG;
        end else if (i_cfg.valid) begin
            r_intensity_mode <= i_cfg.data;
        end
    end

    // coefficient memory: write on load words, read at the tap pointer
    always_ff @(posedge i_clk) begin
        if (acc_in && (i_in.mode == MODE_LOAD)
            && ({{(32 - IDX_W){1'b0}}, i_in.coeff_index} < 32'(STORE_DEPTH))) begin
            r_mem[i_in.coeff_index[TAP_W-1:0]] <= i_in.coeff_value;
        end
        r_coef1 <= r_mem[r_tap];
    end

    always_comb begin
        n_tap = r_tap;
        if (acc_in && (i_in.mode == MODE_PIXEL)) begin
            if (i_in.last_pixel || (r_tap == TAP_W'(STORE_DEPTH - 1))) begin
                n_tap = '0;
            end else begin
                n_tap = r_tap + 1'b1;
            end
        end
    end

    always_comb begin
        n_acc_r = sat_add(r_acc_r, r_mr2);
        n_acc_g = sat_add(r_acc_g, r_mg2);
        n_acc_b = sat_add(r_acc_b, r_mb2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_acc_r <= '0;
            r_acc_g <= '0;
            r_acc_b <= '0;
        end else begin
            r_tap <= n_tap;
            r_v1  <= acc_in && (i_in.mode == MODE_PIXEL);
            r_v2  <= r_v1;
            r_v3  <= r_v2 && r_last2;
            r_v4  <= r_v3;
            if (r_v2) begin
                if (r_last2) begin
                    r_acc_r <= '0;
                    r_acc_g <= '0;
                    r_acc_b <= '0;
                end else begin
                    r_acc_r <= n_acc_r;
                    r_acc_g <= n_acc_g;
                    r_acc_b <= n_acc_b;
                end
            end
        end
    end

    assign tot3 = {2'b00, r_sr3} + {2'b00, r_sg3} + {2'b00, r_sb3};

    always_ff @(posedge i_clk) begin
        r_last1 <= i_in.last_pixel;
        r_pr1   <= i_in.pixel_r;
        r_pg1   <= i_in.pixel_g;
        r_pb1   <= i_in.pixel_b;
        r_row1  <= i_in.cell_row;
        r_col1  <= i_in.cell_col;

        r_last2 <= r_last1;
        r_mr2   <= r_coef1 * r_pr1;
        r_mg2   <= r_coef1 * r_pg1;
        r_mb2   <= r_coef1 * r_pb1;
        r_row2  <= r_row1;
        r_col2  <= r_col1;

        r_sr3   <= clip(n_acc_r);
        r_sg3   <= clip(n_acc_g);
        r_sb3   <= clip(n_acc_b);
        r_ovf3  <= (n_acc_r > {{(ACC_W - SUM_W){1'b0}}, SUM_MAX})
                || (n_acc_g > {{(ACC_W - SUM_W){1'b0}}, SUM_MAX})
                || (n_acc_b > {{(ACC_W - SUM_W){1'b0}}, SUM_MAX});
        r_row3  <= r_row2;
        r_col3  <= r_col2;

        r_sr4   <= r_sr3;
        r_sg4   <= r_sg3;
        r_sb4   <= r_sb3;
        r_ovf4  <= r_ovf3;
        r_row4  <= r_row3;
        r_col4  <= r_col3;
        r_lr4   <= r_sr3 * LUMA_WR;
        r_lg4   <= r_sg3 * LUMA_WG;
        r_lb4   <= r_sb3 * LUMA_WB;
        r_t4    <= tot3[TOT_W-1:COEF_W];
    end

    always_comb begin
        luma_y = {2'b00, r_lr4} + {2'b00, r_lg4} + {2'b00, r_lb4};
        avg_p  = r_t4 * AVG_RECIP;
        if (r_intensity_mode == INT_LUMA) begin
            inten = luma_y[2*COEF_W +: INT_W];
        end else begin
            inten = avg_p[AVG_SHIFT +: INT_W];
        end
    end

    // output FIFO, credit count covers words still in the pipe
    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            r_fifo[r_wr] <= '{out_row:   r_row4,
                              out_col:   r_col4,
                              sum_r:     r_sr4,
                              sum_g:     r_sg4,
                              sum_b:     r_sb4,
                              intensity: inten,
                              overflow:  r_ovf4};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_v4) begin
                r_wr <= (r_wr == FPTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (acc_out) begin
                r_rd <= (r_rd == FPTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_fcnt <= r_fcnt + CNT_W'(r_v4) - CNT_W'(acc_out);
            r_cnt  <= r_cnt + CNT_W'(win_end) - CNT_W'(acc_out);
        end
    end

    assign o_out.valid     = (r_fcnt != '0);
    assign o_out.out_row   = r_fifo[r_rd].out_row;
    assign o_out.out_col   = r_fifo[r_rd].out_col;
    assign o_out.sum_r     = r_fifo[r_rd].sum_r;
    assign o_out.sum_g     = r_fifo[r_rd].sum_g;
    assign o_out.sum_b     = r_fifo[r_rd].sum_b;
    assign o_out.intensity = r_fifo[r_rd].intensity;
    assign o_out.overflow  = r_fifo[r_rd].overflow;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(OUT_FIFO_DEPTH)) && (r_fcnt <= r_cnt))
        else $error("output credit count out of range");

    a_tap_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_end |=> (r_tap == '0))
        else $error("tap pointer not cleared at window end");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_end |=> ##3 r_v4)
        else $error("window result lost in pipeline");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |->
            ((o_out.sum_r == SUM_MAX) || (o_out.sum_g == SUM_MAX) || (o_out.sum_b == SUM_MAX)))
        else $error("overflow flagged without a saturated sum");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2) |=> ((r_acc_r == '0) && (r_acc_g == '0) && (r_acc_b == '0)))
        else $error("accumulators not cleared after window");

endmodule

// File: tb/sv/rwci_window_checker.sv
module rwci_window_checker
    import rwci_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rwci_pix_if  i_pix,
    rwci_cfg_if  i_cfg,
    rwci_res_if  i_res,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              TAPS    = MAX_TAPS_DEFAULT;
    localparam logic [15:0]     W_RED   = 16'd19595;
    localparam logic [15:0]     W_GREEN = 16'd38470;
    localparam logic [15:0]     W_BLUE  = 16'd7471;

    logic [COEF_W-1:0] kernel [TAPS];
    logic [IDX_W-1:0]  tap;
    logic [ACC_W-1:0]  red_acc;
    logic [ACC_W-1:0]  green_acc;
    logic [ACC_W-1:0]  blue_acc;
    logic              luma_sel;
    t_result           window_results [$];
    int                mismatches  = 0;
    int                outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    function automatic logic [ACC_W-1:0] sat_mac(input logic [ACC_W-1:0] acc,
                                                 input logic [COEF_W-1:0] coef,
                                                 input logic [PIX_W-1:0] sample);
        logic [ACC_W:0] t;
        t = {1'b0, acc} + (ACC_W+1)'(coef) * (ACC_W+1)'(sample);
        return t[ACC_W] ? {ACC_W{1'b1}} : t[ACC_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] clip(input logic [ACC_W-1:0] acc, inout logic ovf);
        if (|acc[ACC_W-1:SUM_W]) begin
            ovf = 1'b1;
            return {SUM_W{1'b1}};
        end
        return acc[SUM_W-1:0];
    endfunction

    function automatic t_result close_window(input logic [POS_W-1:0] row,
                                             input logic [POS_W-1:0] col);
        t_result          r;
        logic             ovf;
        logic [TOT_W-1:0] total;
        logic [TOT_W-1:0] third;
        logic [63:0]      luma;
        ovf       = 1'b0;
        r.out_row = row;
        r.out_col = col;
        r.sum_r   = clip(red_acc, ovf);
        r.sum_g   = clip(green_acc, ovf);
        r.sum_b   = clip(blue_acc, ovf);
        if (luma_sel == INT_LUMA) begin
            luma = 64'(W_RED) * 64'(r.sum_r) + 64'(W_GREEN) * 64'(r.sum_g)
                 + 64'(W_BLUE) * 64'(r.sum_b);
            r.intensity = luma[32 +: INT_W];
        end else begin
            total = TOT_W'(r.sum_r) + TOT_W'(r.sum_g) + TOT_W'(r.sum_b);
            third = total / TOT_W'(3);
            r.intensity = third[COEF_W +: INT_W];
        end
        r.overflow = ovf;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            tap       = '0;
            red_acc   = '0;
            green_acc = '0;
            blue_acc  = '0;
            luma_sel  = INT_AVG;
            window_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = {i_res.out_row, i_res.out_col, i_res.sum_r, i_res.sum_g, i_res.sum_b,
                       i_res.intensity, i_res.overflow};
                if (window_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result word: row %0d col %0d r %h g %h b %h",
                                 got.out_row, got.out_col, got.sum_r, got.sum_g, got.sum_b);
                    end
                    mismatches++;
                end else begin
                    want = window_results.pop_front();
                    if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                        got.sum_r !== want.sum_r || got.sum_g !== want.sum_g ||
                        got.sum_b !== want.sum_b || got.intensity !== want.intensity ||
                        got.overflow !== want.overflow) begin
                        if (mismatches < 10) begin
                            $display("result mismatch: got row %0d col %0d r %h g %h b %h int %0d ovf %b",
                                     got.out_row, got.out_col, got.sum_r, got.sum_g,
                                     got.sum_b, got.intensity, got.overflow);
                            $display("                 exp row %0d col %0d r %h g %h b %h int %0d ovf %b",
                                     want.out_row, want.out_col, want.sum_r, want.sum_g,
                                     want.sum_b, want.intensity, want.overflow);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                luma_sel = i_cfg.data;
            end
            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.mode == MODE_LOAD) begin
                    kernel[i_pix.coeff_index] = i_pix.coeff_value;
                end else begin
                    red_acc   = sat_mac(red_acc, kernel[tap], i_pix.pixel_r);
                    green_acc = sat_mac(green_acc, kernel[tap], i_pix.pixel_g);
                    blue_acc  = sat_mac(blue_acc, kernel[tap], i_pix.pixel_b);
                    tap       = tap + IDX_W'(1);
                    if (i_pix.last_pixel) begin
                        window_results.push_back(close_window(i_pix.cell_row, i_pix.cell_col));
                        red_acc   = '0;
                        green_acc = '0;
                        blue_acc  = '0;
                        tap       = '0;
                    end
                end
            end
        end
        outstanding = window_results.size();
    end

endmodule

// File: tb/sv/rgb_window_convolve_intensity_core_test.sv
module rgb_window_convolve_intensity_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rwci_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   hold_asked   = 0;
    int   words_sent   = 0;
    int   err_cnt;
    int   pending_cnt;

    rwci_pix_if pix_if();
    rwci_cfg_if cfg_if();
    rwci_res_if res_if();

    rgb_window_convolve_intensity_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pix_if),
        .i_cfg   (cfg_if),
        .o_out   (res_if)
    );

    rwci_window_checker window_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if),
        .i_cfg     (cfg_if),
        .i_res     (res_if),
        .o_errors  (err_cnt),
        .o_pending (pending_cnt)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [PIX_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic md, input logic [IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] cv, input logic [PIX_W-1:0] r,
                             input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                             input logic lst, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.mode        <= md;
        pix_if.coeff_index <= idx;
        pix_if.coeff_value <= cv;
        pix_if.pixel_r     <= r;
        pix_if.pixel_g     <= g;
        pix_if.pixel_b     <= b;
        pix_if.last_pixel  <= lst;
        pix_if.cell_row    <= row;
        pix_if.cell_col    <= col;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        send_word(MODE_LOAD, idx, val, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                  1'($urandom), POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic lst);
        send_word(MODE_PIXEL, IDX_W'($urandom), COEF_W'($urandom), r, g, b, lst,
                  POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic load_kernel(input bit full_scale);
        for (int i = 0; i < MAX_TAPS_DEFAULT; i++) begin
            load_coef(IDX_W'(i), full_scale ? {COEF_W{1'b1}} : rand_coef());
        end
    endtask

    // heavy windows drive the accumulators into saturation
    task automatic run_window(input int len, input bit heavy);
        for (int i = 0; i < len; i++) begin
            if (!heavy && $urandom_range(0, 99) < 3) begin
                load_coef(IDX_W'($urandom), rand_coef());
            end
            if (heavy) begin
                send_pixel('1, PIX_W'($urandom_range(240, 255)), rand_sample(), i == len - 1);
            end else begin
                send_pixel(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
            end
        end
    endtask

    task automatic run_random(input int count);
        int stop;
        int pick;
        stop = words_sent + count;
        while (words_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_word(1'($urandom), IDX_W'($urandom), COEF_W'($urandom), PIX_W'($urandom),
                          PIX_W'($urandom), PIX_W'($urandom), 1'($urandom), POS_W'($urandom),
                          POS_W'($urandom));
            end else if (pick < 20) begin
                load_coef(IDX_W'($urandom), rand_coef());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    run_window($urandom_range(1, 9), 1'b0);
                end else if (pick < 97) begin
                    run_window($urandom_range(10, 64), 1'b0);
                end else begin
                    run_window($urandom_range(65, 130), 1'b0);
                end
            end
        end
    endtask

    task automatic drain();
        pix_if.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic sel);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= sel;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        int stall_cnt;
        stall_cnt = 0;
        while (stall_cnt < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
        end
        $display("rgb_window_convolve_intensity_core_test: done, errors");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.mode        <= MODE_LOAD;
        pix_if.coeff_index <= '0;
        pix_if.coeff_value <= '0;
        pix_if.pixel_r     <= '0;
        pix_if.pixel_g     <= '0;
        pix_if.pixel_b     <= '0;
        pix_if.last_pixel  <= 1'b0;
        pix_if.cell_row    <= '0;
        pix_if.cell_col    <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.data        <= INT_AVG;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(INT_LUMA);

        // every slot written before any pixel reads it
        load_kernel(1'b0);
        load_coef(IDX_W'(0), '1);
        load_coef(IDX_W'(1), '1);
        load_coef(IDX_W'(2), '0);
        load_coef(IDX_W'(3), COEF_W'(1));
        send_word(MODE_PIXEL, '0, '0, '1, '1, '1, 1'b1, '1, '1);
        send_word(MODE_PIXEL, '1, '1, '0, '0, '0, 1'b1, '0, '0);
        send_pixel('1, '0, '0, 1'b0);
        send_word(MODE_PIXEL, '0, '0, '1, '1, '1, 1'b1, POS_W'(12'hABC), POS_W'(12'h543));
        // load in mid-window
        send_pixel(PIX_W'(10), PIX_W'(20), PIX_W'(30), 1'b0);
        load_coef(IDX_W'(1), COEF_W'(16'h8000));
        send_pixel(PIX_W'(200), PIX_W'(100), PIX_W'(50), 1'b0);
        send_pixel(PIX_W'(1), PIX_W'(2), PIX_W'(3), 1'b1);
        send_word(MODE_LOAD, IDX_W'(5), COEF_W'(16'h1234), '1, '1, '1, 1'b1, '1, '1);
        drain();
        write_mode(INT_AVG);
        send_pixel('1, '1, '1, 1'b0);
        send_pixel('1, '1, '1, 1'b0);
        send_pixel('1, '1, '1, 1'b1);
        send_pixel('1, '1, '1, 1'b1);
        send_pixel(PIX_W'(1), PIX_W'(128), PIX_W'(254), 1'b1);
        drain();

        src_idle_pct = 18;
        snk_idle_pct = 86;
        run_random(450);
        drain();
        write_mode(INT_LUMA);

        src_idle_pct = 86;
        snk_idle_pct = 18;
        run_random(450);
        drain();
        write_mode(INT_AVG);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        load_kernel(1'b1);
        run_window($urandom_range(270, 330), 1'b1);
        load_kernel(1'b0);
        drain();
        // receiver holds off while single-pixel windows pile up
        hold_asked++;
        for (int i = 0; i < 40; i++) begin
            send_pixel(rand_sample(), rand_sample(), rand_sample(), 1'b1);
        end
        drain();
        write_mode(INT_LUMA);
        run_random(300);
        drain();
        repeat (12) @(negedge i_clk);

        if (err_cnt == 0 && pending_cnt == 0) begin
            $display("rgb_window_convolve_intensity_core_test: done, clean");
        end else begin
            $display("rgb_window_convolve_intensity_core_test: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rwci_pkg.sv
rtl/core/rwci_ifs.sv
rtl/core/rgb_window_convolve_intensity_core.sv
tb/sv/rwci_window_checker.sv
tb/sv/rgb_window_convolve_intensity_core_test.sv
